@@ hw/rtl/ale_pkg.sv @@
// Shared types, constants and the slot policy for the array list engine.
package ale_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Widths fixed by the request and response fields
   localparam int SIZE_W  = 7;
   localparam int CMD_W   = 3;
   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;

   // Slot policy: grow to n + n/8 + pad, rounded down to a multiple of four
   localparam logic [SIZE_W:0] SLOT_PAD   = (SIZE_W+1)'(6);
   localparam logic [SIZE_W:0] SLOT_ROUND = (SIZE_W+1)'(3);

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_INSERT  = 3'd1,
      CMD_DELETE  = 3'd2,
      CMD_SUBLIST = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   // Control broadcast to every cell of the store
   typedef struct packed {
      logic              shift_up;    // open a gap at index and load the new word
      logic              shift_down;  // close the gap at index
      logic              snap;        // copy stored words into the read taps
      logic              advance;     // move the read taps one place toward cell 0
      logic [SIZE_W-1:0] index;
   } cell_ctrl_type;

   // Slot count after the size changes to n
   function automatic logic [SIZE_W-1:0] next_slots(input logic [SIZE_W-1:0] slots,
                                                    input logic [SIZE_W-1:0] n);
      logic [SIZE_W:0] grown;
      grown = ({1'b0, n} + {4'b0000, n[SIZE_W-1:3]} + SLOT_PAD) & ~SLOT_ROUND;
      // A size step of one never trips the small-step rounding rule
      if (slots >= n && n >= (slots >> 1)) begin
         next_slots = slots;
      end else if (n == '0) begin
         next_slots = '0;
      end else begin
         next_slots = grown[SIZE_W-1:0];
      end
   endfunction

endpackage

@@ hw/rtl/array_list_engine.sv @@
// Top level of the array list engine: command decode, cell row and response register.
// Append, insert, delete, clear, bad commands and empty sublists are done when
// accepted, and their response is registered in the output register. Insert and
// delete move every stored word at or above the index at once. A non-empty
// sublist holds off new requests until its last word is registered: the words
// are copied into a read chain that moves one cell toward cell 0 per cycle while
// skipping or while the output register is free, the words below the clamped low
// bound are skipped, then one word leaves per cycle unless the response stalls.
// No clearing pass runs after reset; cells hold nothing meaningful until written.
module array_list_engine #(
   parameter int CAPACITY   = ale_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ale_pkg::CMD_W-1:0]     req_command,
   input  logic signed [ale_pkg::POS_W-1:0] req_position,
   input  logic [ale_pkg::VALUE_W-1:0]   req_element_value,
   input  logic [ale_pkg::SIZE_W-1:0]    req_range_low,
   input  logic [ale_pkg::SIZE_W-1:0]    req_range_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [ale_pkg::VALUE_W-1:0]   rsp_data_out,
   output logic                          rsp_data_valid,
   output logic                          rsp_last_of_run,
   output logic [ale_pkg::SIZE_W-1:0]    rsp_list_size,
   output logic [ale_pkg::SIZE_W-1:0]    rsp_slot_count
);

   localparam int SW = ale_pkg::SIZE_W;
   localparam logic [SW-1:0] CAP_SIZE = SW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] slots_ff, slots_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] hi_ff, hi_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [ale_pkg::VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                         rsp_dvalid_ff, rsp_dvalid_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [SW-1:0]                rsp_size_ff, rsp_size_in;
   logic [SW-1:0]                rsp_slots_ff, rsp_slots_in;

   ale_pkg::cell_ctrl_type ctrl;
   logic [DATA_WIDTH-1:0] new_word;
   logic [DATA_WIDTH-1:0] word_q [CAPACITY];
   logic [DATA_WIDTH-1:0] read_q [CAPACITY];

   logic out_free, accept, scanning, skipping, emit, emit_last;
   logic full, del_err, sub_empty;
   logic signed [SW+1:0] ins_sum;
   logic [SW-1:0] ins_idx, lo_c, hi_c, hi_raw;

   // Handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // Resolve the insert index: negative counts from the end, clamp to 0..size
   assign ins_sum = req_position[ale_pkg::POS_W-1]
                  ? (SW+2)'(req_position) + (SW+2)'({2'b00, size_ff})
                  : (SW+2)'(req_position);
   always_comb begin
      if (ins_sum[SW+1]) begin
         ins_idx = '0;
      end else if (ins_sum[SW:0] > {1'b0, size_ff}) begin
         ins_idx = size_ff;
      end else begin
         ins_idx = ins_sum[SW-1:0];
      end
   end

   assign full    = size_ff >= CAP_SIZE;
   assign del_err = req_position[ale_pkg::POS_W-1] || (req_position[SW-1:0] >= size_ff);

   // Clamp the sublist bounds to size, then raise high to low
   assign lo_c      = (req_range_low > size_ff) ? size_ff : req_range_low;
   assign hi_raw    = (req_range_high > size_ff) ? size_ff : req_range_high;
   assign hi_c      = (hi_raw < lo_c) ? lo_c : hi_raw;
   assign sub_empty = (hi_c == lo_c);

   // Sublist scan: skip words below low, then emit one per free output cycle
   assign scanning  = (state_ff == ST_SCAN);
   assign skipping  = scanning && (pos_ff < lo_ff);
   assign emit      = scanning && !skipping && out_free;
   assign emit_last = (SW'(pos_ff + 1'b1) == hi_ff);

   assign new_word = DATA_WIDTH'(req_element_value);

   // Decode the request into cell control, state updates and a response
   always_comb begin
      ctrl          = '0;
      state_in      = state_ff;
      size_in       = size_ff;
      slots_in      = slots_ff;
      pos_in        = pos_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_dvalid_in = rsp_dvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_slots_in  = rsp_slots_ff;

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b0;
         rsp_data_in   = '0;
         rsp_dvalid_in = 1'b0;
         rsp_last_in   = 1'b1;
         case (ale_pkg::cmd_type'(req_command))
            ale_pkg::CMD_APPEND, ale_pkg::CMD_INSERT: begin
               if (full) begin
                  rsp_status_in = 1'b1;
               end else begin
                  ctrl.shift_up = 1'b1;
                  ctrl.index    = (ale_pkg::cmd_type'(req_command) == ale_pkg::CMD_APPEND)
                                ? size_ff : ins_idx;
                  size_in  = SW'(size_ff + 1'b1);
                  slots_in = ale_pkg::next_slots(slots_ff, size_in);
               end
            end
            ale_pkg::CMD_DELETE: begin
               if (del_err) begin
                  rsp_status_in = 1'b1;
               end else begin
                  ctrl.shift_down = 1'b1;
                  ctrl.index      = req_position[SW-1:0];
                  size_in  = SW'(size_ff - 1'b1);
                  slots_in = ale_pkg::next_slots(slots_ff, size_in);
               end
            end
            ale_pkg::CMD_SUBLIST: begin
               if (!sub_empty) begin
                  // Start the scan; results come from the read chain
                  rsp_valid_in = 1'b0;
                  ctrl.snap    = 1'b1;
                  state_in     = ST_SCAN;
                  pos_in       = '0;
                  lo_in        = lo_c;
                  hi_in        = hi_c;
               end
            end
            ale_pkg::CMD_CLEAR: begin
               size_in  = '0;
               slots_in = '0;
            end
            default: begin
               rsp_status_in = 1'b1;
            end
         endcase
         rsp_size_in  = size_in;
         rsp_slots_in = slots_in;
      end else if (skipping || emit) begin
         ctrl.advance = 1'b1;
         pos_in       = SW'(pos_ff + 1'b1);
         if (emit) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_data_in   = ale_pkg::VALUE_W'(read_q[0]);
            rsp_dvalid_in = 1'b1;
            rsp_last_in   = emit_last;
            rsp_size_in   = size_ff;
            rsp_slots_in  = slots_ff;
            if (emit_last) begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   // Row of storage cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w, right_r;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = word_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
         assign right_r = '0;
      end else begin : g_inner
         assign right_w = word_q[i+1];
         assign right_r = read_q[i+1];
      end
      ale_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_word   (new_word),
         .left_word  (left_w),
         .right_word (right_w),
         .right_read (right_r),
         .word       (word_q[i]),
         .read       (read_q[i])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan counters and response payload
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_slots_ff  <= rsp_slots_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_data_valid  = rsp_dvalid_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_list_size   = rsp_size_ff;
   assign rsp_slot_count  = rsp_slots_ff;

endmodule

@@ hw/rtl/ale_cell.sv @@
// One storage cell of the list: a stored word and a read tap.
module ale_cell #(
   parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                     clock,
   input  ale_pkg::cell_ctrl_type   ctrl,
   input  logic [DATA_WIDTH-1:0]    new_word,
   input  logic [DATA_WIDTH-1:0]    left_word,
   input  logic [DATA_WIDTH-1:0]    right_word,
   input  logic [DATA_WIDTH-1:0]    right_read,
   output logic [DATA_WIDTH-1:0]    word,
   output logic [DATA_WIDTH-1:0]    read
);

   localparam logic [ale_pkg::SIZE_W-1:0] MY_INDEX = ale_pkg::SIZE_W'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] read_ff, read_in;

   // Pick the next stored word: take from the left, load, take from the right or hold
   always_comb begin
      word_in = word_ff;
      if (ctrl.shift_up) begin
         if (MY_INDEX > ctrl.index) begin
            word_in = left_word;
         end else if (MY_INDEX == ctrl.index) begin
            word_in = new_word;
         end
      end else if (ctrl.shift_down) begin
         if (MY_INDEX >= ctrl.index) begin
            word_in = right_word;
         end
      end
   end

   // Load the read tap from the store, or pass the right neighbor's tap down
   always_comb begin
      read_in = read_ff;
      if (ctrl.snap) begin
         read_in = word_ff;
      end else if (ctrl.advance) begin
         read_in = right_read;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      read_ff <= read_in;
   end

   assign word = word_ff;
   assign read = read_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the array list engine: directed, fill and random request traffic.
`timescale 1ns / 100ps

module testbench;

   localparam int LIST_CAPACITY = ale_pkg::CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [ale_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [ale_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef struct {
      logic                         status;
      logic [ale_pkg::VALUE_W-1:0]  data_out;
      logic                         data_valid;
      logic                         last_of_run;
      logic [ale_pkg::SIZE_W-1:0]   list_size;
      logic [ale_pkg::SIZE_W-1:0]   slot_count;
   } list_reply_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [ale_pkg::CMD_W-1:0]           req_command = '0;
   logic signed [ale_pkg::POS_W-1:0]    req_position = '0;
   logic [ale_pkg::VALUE_W-1:0]         req_element_value = '0;
   logic [ale_pkg::SIZE_W-1:0]          req_range_low = '0;
   logic [ale_pkg::SIZE_W-1:0]          req_range_high = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_status;
   logic [ale_pkg::VALUE_W-1:0]         rsp_data_out;
   logic                                rsp_data_valid;
   logic                                rsp_last_of_run;
   logic [ale_pkg::SIZE_W-1:0]          rsp_list_size;
   logic [ale_pkg::SIZE_W-1:0]          rsp_slot_count;

   // Shadow copy of the list and its slot register
   logic [ale_pkg::VALUE_W-1:0] list_words [LIST_CAPACITY];
   int                          word_count = 0;
   int                          slot_total = 0;
   list_reply_type              expected_replies [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;

   array_list_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_list_size     (rsp_list_size),
      .rsp_slot_count    (rsp_slot_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Record one expected response with the current size and slot count
   function automatic void push_reply(input logic status,
                                      input logic [ale_pkg::VALUE_W-1:0] data,
                                      input logic data_valid, input logic last);
      list_reply_type r;
      r.status      = status;
      r.data_out    = data;
      r.data_valid  = data_valid;
      r.last_of_run = last;
      r.list_size   = word_count[ale_pkg::SIZE_W-1:0];
      r.slot_count  = slot_total[ale_pkg::SIZE_W-1:0];
      expected_replies.push_back(r);
   endfunction

   // Move the size to n and follow the over-allocation rules for the slot count
   function automatic void resize_list(input int n);
      int grown;
      if (slot_total >= n && n >= (slot_total >> 1)) begin
         word_count = n;
         return;
      end
      grown = (n + (n >> 3) + 6) & ~3;
      if (n > word_count && n - word_count > grown - n) begin
         grown = (n + 3) & ~3;
      end
      if (n == 0) begin
         grown = 0;
      end
      word_count = n;
      slot_total = grown & 'h7F;
   endfunction

   // Update the shadow list for one accepted request and queue its responses
   function automatic void apply_list_command(input logic [ale_pkg::CMD_W-1:0] cmd,
                                              input logic signed [ale_pkg::POS_W-1:0] pos,
                                              input logic [ale_pkg::VALUE_W-1:0] value,
                                              input logic [ale_pkg::SIZE_W-1:0] lo_in,
                                              input logic [ale_pkg::SIZE_W-1:0] hi_in);
      int size;
      int idx;
      int lo;
      int hi;
      int i;
      size = word_count;
      case (cmd)
         ale_pkg::CMD_APPEND, ale_pkg::CMD_INSERT: begin
            if (size >= LIST_CAPACITY) begin
               push_reply(1'b1, '0, 1'b0, 1'b1);
            end else begin
               idx = size;
               if (cmd == ale_pkg::CMD_INSERT) begin
                  idx = int'(pos);
                  if (idx < 0) begin
                     idx += size;
                     if (idx < 0) idx = 0;
                  end
                  if (idx > size) idx = size;
               end
               resize_list(size + 1);
               for (i = size; i > idx; i--) list_words[i] = list_words[i-1];
               list_words[idx] = value;
               push_reply(1'b0, '0, 1'b0, 1'b1);
            end
         end
         ale_pkg::CMD_DELETE: begin
            idx = int'(pos);
            if (idx < 0 || idx >= size) begin
               push_reply(1'b1, '0, 1'b0, 1'b1);
            end else begin
               for (i = idx; i + 1 < size; i++) list_words[i] = list_words[i+1];
               resize_list(size - 1);
               push_reply(1'b0, '0, 1'b0, 1'b1);
            end
         end
         ale_pkg::CMD_SUBLIST: begin
            lo = (int'(lo_in) > size) ? size : int'(lo_in);
            hi = (int'(hi_in) > size) ? size : int'(hi_in);
            if (hi < lo) hi = lo;
            if (hi == lo) begin
               push_reply(1'b0, '0, 1'b0, 1'b1);
            end else begin
               for (i = lo; i < hi; i++) begin
                  push_reply(1'b0, list_words[i], 1'b1, i == hi - 1);
               end
            end
         end
         ale_pkg::CMD_CLEAR: begin
            word_count = 0;
            slot_total = 0;
            push_reply(1'b0, '0, 1'b0, 1'b1);
         end
         default: begin
            push_reply(1'b1, '0, 1'b0, 1'b1);
         end
      endcase
   endfunction

   // Offer one request, hold it until accepted, then predict its responses
   task automatic send_request(input logic [ale_pkg::CMD_W-1:0] cmd,
                               input logic signed [ale_pkg::POS_W-1:0] pos,
                               input logic [ale_pkg::VALUE_W-1:0] value,
                               input logic [ale_pkg::SIZE_W-1:0] lo,
                               input logic [ale_pkg::SIZE_W-1:0] hi);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_position      <= pos;
      req_element_value <= value;
      req_range_low     <= lo;
      req_range_high    <= hi;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      apply_list_command(cmd, pos, value, lo, hi);
   endtask

   // Short directed pass over bounds, clamping, errors and every command
   task automatic test_directed_cases();
      send_request(ale_pkg::CMD_DELETE, 8'sd0, '0, '0, '0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd0, 7'd127);
      send_request(ale_pkg::CMD_APPEND, 8'sd0, 32'h0000_0000, '0, '0);
      send_request(ale_pkg::CMD_APPEND, 8'sd0, 32'hFFFF_FFFF, '0, '0);
      send_request(ale_pkg::CMD_INSERT, 8'sd127, 32'hA5A5_A5A5, '0, '0);
      send_request(ale_pkg::CMD_INSERT, 8'sh80, 32'h0000_0001, '0, '0);
      send_request(ale_pkg::CMD_INSERT, -8'sd1, 32'h0000_0002, '0, '0);
      send_request(ale_pkg::CMD_INSERT, 8'sd0, 32'h5A5A_5A5A, '0, '0);
      send_request(ale_pkg::CMD_INSERT, 8'sd2, 32'h8000_0000, '0, '0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd0, 7'd127);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd5, 7'd2);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd127, 7'd0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd2, 7'd4);
      send_request(ale_pkg::CMD_DELETE, -8'sd1, '0, '0, '0);
      send_request(ale_pkg::CMD_DELETE, 8'sd127, '0, '0, '0);
      send_request(ale_pkg::CMD_DELETE, 8'sd7, '0, '0, '0);
      send_request(ale_pkg::CMD_DELETE, 8'sd0, '0, '0, '0);
      send_request(ale_pkg::CMD_DELETE, 8'sd5, '0, '0, '0);
      send_request(CMD_UNUSED_LO, -8'sd1, 32'hFFFF_FFFF, 7'd127, 7'd127);
      send_request(CMD_UNUSED_HI, 8'sd0, '0, '0, '0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd0, 7'd127);
      send_request(ale_pkg::CMD_CLEAR, 8'sd0, '0, '0, '0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd0, 7'd127);
      send_request(ale_pkg::CMD_APPEND, 8'sd0, 32'h1234_5678, '0, '0);
   endtask

   // Mixed random traffic, weighted toward growth, mostly with in-range indexes
   task automatic test_random_mix(input int items);
      int pick;
      logic [ale_pkg::CMD_W-1:0] cmd;
      logic signed [ale_pkg::POS_W-1:0] pos;
      logic [ale_pkg::SIZE_W-1:0] lo;
      logic [ale_pkg::SIZE_W-1:0] hi;
      repeat (items) begin
         pick = $urandom_range(99);
         pos  = ale_pkg::POS_W'($urandom);
         lo   = ale_pkg::SIZE_W'($urandom);
         hi   = ale_pkg::SIZE_W'($urandom);
         if (pick < 30) begin
            cmd = ale_pkg::CMD_APPEND;
         end else if (pick < 58) begin
            cmd = ale_pkg::CMD_INSERT;
            if ($urandom_range(1) == 1) begin
               pos = ale_pkg::POS_W'(int'($urandom_range(2 * word_count)) - word_count);
            end
         end else if (pick < 80) begin
            cmd = ale_pkg::CMD_DELETE;
            if ($urandom_range(3) != 0 && word_count > 0) begin
               pos = ale_pkg::POS_W'($urandom_range(word_count - 1));
            end
         end else if (pick < 92) begin
            cmd = ale_pkg::CMD_SUBLIST;
            if ($urandom_range(3) != 0) begin
               lo = ale_pkg::SIZE_W'($urandom_range(word_count));
               hi = ale_pkg::SIZE_W'($urandom_range(word_count));
            end
         end else if (pick < 95) begin
            cmd = ale_pkg::CMD_CLEAR;
         end else begin
            cmd = ale_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         end
         send_request(cmd, pos, $urandom, lo, hi);
      end
   endtask

   // Fill the list to capacity, hit the full errors, read it all back, then shrink
   task automatic test_fill_to_capacity();
      send_request(ale_pkg::CMD_CLEAR, 8'sd0, '0, '0, '0);
      while (word_count < LIST_CAPACITY) begin
         if ($urandom_range(1) == 1) begin
            send_request(ale_pkg::CMD_APPEND, ale_pkg::POS_W'($urandom), $urandom,
                         ale_pkg::SIZE_W'($urandom), ale_pkg::SIZE_W'($urandom));
         end else begin
            send_request(ale_pkg::CMD_INSERT, ale_pkg::POS_W'($urandom), $urandom,
                         ale_pkg::SIZE_W'($urandom), ale_pkg::SIZE_W'($urandom));
         end
      end
      send_request(ale_pkg::CMD_APPEND, 8'sd0, $urandom, '0, '0);
      send_request(ale_pkg::CMD_INSERT, 8'sh80, $urandom, '0, '0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, 7'd0, 7'd127);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0, ale_pkg::SIZE_W'($urandom_range(63)),
                   ale_pkg::SIZE_W'($urandom_range(127)));
      repeat (6) begin
         send_request(ale_pkg::CMD_DELETE, ale_pkg::POS_W'($urandom_range(word_count - 1)),
                      '0, '0, '0);
      end
      send_request(ale_pkg::CMD_DELETE, ale_pkg::POS_W'(word_count), '0, '0, '0);
      send_request(ale_pkg::CMD_SUBLIST, 8'sd0, '0,
                   ale_pkg::SIZE_W'($urandom_range(word_count)), 7'd127);
      send_request(ale_pkg::CMD_INSERT, ale_pkg::POS_W'($urandom), $urandom, '0, '0);
      send_request(ale_pkg::CMD_INSERT, ale_pkg::POS_W'($urandom), $urandom, '0, '0);
   endtask

   // Stall the response side at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Compare each accepted response with the oldest expectation
   function automatic void check_field(input string name,
                                       input logic [ale_pkg::VALUE_W-1:0] want,
                                       input logic [ale_pkg::VALUE_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_replies
      list_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_replies.size() == 0) begin
            $error("response with no request waiting for it");
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("status", ale_pkg::VALUE_W'(want.status),
                        ale_pkg::VALUE_W'(rsp_status));
            check_field("data_out", want.data_out, rsp_data_out);
            check_field("data_valid", ale_pkg::VALUE_W'(want.data_valid),
                        ale_pkg::VALUE_W'(rsp_data_valid));
            check_field("last_of_run", ale_pkg::VALUE_W'(want.last_of_run),
                        ale_pkg::VALUE_W'(rsp_last_of_run));
            check_field("list_size", ale_pkg::VALUE_W'(want.list_size),
                        ale_pkg::VALUE_W'(rsp_list_size));
            check_field("slot_count", ale_pkg::VALUE_W'(want.slot_count),
                        ale_pkg::VALUE_W'(rsp_slot_count));
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct   = 25;
      rsp_stall_pct = 77;
      test_directed_cases();
      test_random_mix(50);

      req_gap_pct   = 77;
      rsp_stall_pct = 25;
      test_fill_to_capacity();

      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_random_mix(80);

      // Drain the remaining responses
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/ale_pkg.sv
hw/rtl/ale_cell.sv
hw/rtl/array_list_engine.sv
tb/testbench.sv
